// File: design/lcgr_pkg.sv
`timescale 1ns / 1ps
package lcgr_pkg;

  localparam int unsigned WORD_W = 31;
  localparam int unsigned BITS_W = 5;
  localparam int unsigned MULT_W = 15;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [WORD_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t limit;
  } lcgr_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_FOLD,
    BK_SCALE,
    BK_DIV
  } back_state_t;

endpackage

// File: design/lcgr_front.sv
`timescale 1ns / 1ps
module lcgr_front
  import lcgr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  word_t               in_limit,
  input  logic [BITS_W-1:0]   in_mask_bits,
  output logic                head_valid,
  output lcgr_item_t          head_item,
  input  logic                head_take
);

  lcgr_item_t queue [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  word_t      eff_limit;

  // keep the low limit bits in masked mode
  always_comb begin
    if (in_func) begin
      eff_limit = in_limit & ~(LCG_MOD << in_mask_bits);
    end else begin
      eff_limit = in_limit;
    end
  end

  assign in_ready   = (count != 2'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign pop        = head_valid && head_take;
  assign head_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].limit <= eff_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'(QUEUE_DEPTH)) && !pop |=> count == 2'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) || (count == 2'(QUEUE_DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: design/lcgr_back.sv
`timescale 1ns / 1ps
module lcgr_back
  import lcgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  word_t      cfg_seed,
  input  logic       head_valid,
  input  lcgr_item_t head_item,
  output logic       head_take,
  output logic       out_valid,
  input  logic       out_ready,
  output word_t      out_raw,
  output word_t      out_range
);

  back_state_t state;
  back_state_t state_next;

  word_t                   seed;
  logic                    seed_loaded;
  word_t                   gen_state;
  word_t                   limit;
  logic [WORD_W+MULT_W-1:0] prod_gen;
  logic [2*WORD_W-1:0]      prod_scale;

  logic        out_load;
  logic [31:0] fold1;
  logic [31:0] fold2;
  word_t       gen_new;
  word_t       gen_src;
  word_t       div_hi;
  logic [31:0] div_sum;
  word_t       range_calc;

  assign gen_src = seed_loaded ? gen_state : seed;

  // Mersenne fold of the product back under the modulus
  always_comb begin
    fold1 = {1'b0, prod_gen[WORD_W-1:0]} + {17'b0, prod_gen[WORD_W+MULT_W-1:WORD_W]};
    fold2 = {1'b0, fold1[WORD_W-1:0]} + {31'b0, fold1[31]};
    if (fold2 >= {1'b0, LCG_MOD}) begin
      gen_new = WORD_W'(fold2 - {1'b0, LCG_MOD});
    end else begin
      gen_new = fold2[WORD_W-1:0];
    end
  end

  // floor(p / (2^31-1)) = hi + (hi + lo >= 2^31-1), then add one
  always_comb begin
    div_hi     = prod_scale[2*WORD_W-1:WORD_W];
    div_sum    = {1'b0, div_hi} + {1'b0, prod_scale[WORD_W-1:0]};
    range_calc = div_hi + WORD_W'(div_sum >= {1'b0, LCG_MOD}) + WORD_W'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (head_valid) state_next = BK_MUL;
      BK_MUL:   state_next = BK_FOLD;
      BK_FOLD:  state_next = BK_SCALE;
      BK_SCALE: state_next = BK_DIV;
      BK_DIV:   if (!out_valid || out_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    head_take = 1'b0;
    out_load  = 1'b0;
    case (state)
      BK_IDLE: head_take = head_valid;
      BK_DIV:  out_load  = !out_valid || out_ready;
      default: begin
        head_take = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      seed        <= WORD_W'(1);
      seed_loaded <= 1'b0;
      gen_state   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        seed        <= cfg_seed;
        seed_loaded <= 1'b0;
      end else if (state == BK_MUL) begin
        seed_loaded <= 1'b1;
      end
      if (state == BK_FOLD) begin
        gen_state <= gen_new;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      limit <= head_item.limit;
    end
    if (state == BK_MUL) begin
      prod_gen <= (WORD_W+MULT_W)'(gen_src) * (WORD_W+MULT_W)'(LCG_MULT);
    end
    if (state == BK_SCALE) begin
      prod_scale <= (2*WORD_W)'(gen_state) * (2*WORD_W)'(limit);
    end
    if (out_load) begin
      out_raw   <= gen_state;
      out_range <= range_calc;
    end
  end

`ifndef SYNTHESIS
  a_state_reduced: assert property (@(posedge clk) disable iff (rst)
    state == BK_SCALE |-> gen_state != LCG_MOD)
    else $error("generator state not reduced");

  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == BK_DIV)
    else $error("result shown without finishing an item");

  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_range != '0)
    else $error("range number of zero");

  a_seed_used: assert property (@(posedge clk) disable iff (rst)
    state == BK_MUL |=> seed_loaded || $past(cfg_write))
    else $error("seed not marked loaded");
`endif

endmodule

// File: design/minimal_standard_lcg_range.sv
`timescale 1ns / 1ps
// channel  direction  tdata / data                         tuser
// s_axis   in         [30:0] limit, [35:31] mask_bits      [0] func
// m_axis   out        [30:0] raw_value, [61:31] range_number  -
// cfg      in         [30:0] seed                          -
//
// The back sequencer handles one word in steps: queue take, constant multiply,
// modulus fold, scaling multiply, then quotient correction with result load.
// A two-word queue holds classified input while the back is busy.
// Reset (rst, synchronous) empties the queue, drops any result and sets seed to 1.
// A held result stalls only the last step; input keeps filling the queue.
module minimal_standard_lcg_range
  import lcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // limit, mask_bits
  input  logic [0:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // raw_value, range_number
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data        // seed
);

  logic       head_valid;
  lcgr_item_t head_item;
  logic       head_take;
  word_t      out_raw;
  word_t      out_range;

  assign cfg_ready = 1'b1;

  lcgr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_func      (s_axis_tuser[0]),
    .in_limit     (s_axis_tdata[WORD_W-1:0]),
    .in_mask_bits (s_axis_tdata[WORD_W+BITS_W-1:WORD_W]),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_take    (head_take)
  );

  lcgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_seed   (cfg_data),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_take  (head_take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_raw    (out_raw),
    .out_range  (out_range)
  );

  assign m_axis_tdata = {2'b00, out_range, out_raw};

endmodule
